// ----- design/ryuv_pkg.sv -----
// shared constants and types for the rgb/yuv pixel converter
package ryuv_pkg;

  localparam int BYTE_W        = 8;
  localparam int MODE_W        = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CHROMA_OFS    = 128;
  localparam int BYTE_MAX      = 255;

  // conversion mode codes
  localparam logic [MODE_W-1:0] MODE_RGB2YUV = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YUV2RGB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INVERT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd3;

  // raw pixel and its mode, carried alongside the arithmetic through the capture, product and sum stages
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } ryuv_pix_t;

endpackage

// ----- design/ryuv_in_if.sv -----
// pixel request channel into the converter
interface ryuv_in_if;
  import ryuv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_first;
  logic [BYTE_W-1:0] in_second;
  logic [BYTE_W-1:0] in_third;

  modport source (output valid, in_first, in_second, in_third, input ready);
  modport sink (input valid, in_first, in_second, in_third, output ready);
endinterface

// ----- design/ryuv_out_if.sv -----
// converted pixel request channel out of the converter
interface ryuv_out_if;
  import ryuv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_first;
  logic [BYTE_W-1:0] out_second;
  logic [BYTE_W-1:0] out_third;

  modport source (output valid, out_first, out_second, out_third, input ready);
  modport sink (input valid, out_first, out_second, out_third, output ready);
endinterface

// ----- design/ryuv_cfg_if.sv -----
// mode register write channel
interface ryuv_cfg_if;
  import ryuv_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] conversion_mode;

  modport source (output valid, conversion_mode, input ready);
  modport sink (input valid, conversion_mode, output ready);
endinterface

// ----- design/ryuv_prod.sv -----
// product stage: nine coefficient-by-channel multiplies, registered
module ryuv_prod
  import ryuv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_W     = FRAC_BITS + 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  ryuv_pix_t                  up_pix,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output ryuv_pix_t                  dn_pix,
  output logic [8:0][ACC_W-1:0]      dn_term
);

  // coefficients rounded to FRAC_BITS fraction bits
  localparam longint C_YR = ((longint'(299) << FRAC_BITS) + 500) / 1000;
  localparam longint C_YG = ((longint'(587) << FRAC_BITS) + 500) / 1000;
  localparam longint C_YB = ((longint'(114) << FRAC_BITS) + 500) / 1000;
  localparam longint C_UR = ((longint'(169) << FRAC_BITS) + 500) / 1000;
  localparam longint C_UG = ((longint'(331) << FRAC_BITS) + 500) / 1000;
  localparam longint C_HF = ((longint'(500) << FRAC_BITS) + 500) / 1000;
  localparam longint C_VG = ((longint'(419) << FRAC_BITS) + 500) / 1000;
  localparam longint C_VB = ((longint'(81) << FRAC_BITS) + 500) / 1000;
  localparam longint C_RV = ((longint'(14075) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_GU = ((longint'(3455) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_GV = ((longint'(7169) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_BU = ((longint'(17790) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_ONE = longint'(1) << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] K_YR  = ACC_W'(C_YR);
  localparam logic signed [ACC_W-1:0] K_YG  = ACC_W'(C_YG);
  localparam logic signed [ACC_W-1:0] K_YB  = ACC_W'(C_YB);
  localparam logic signed [ACC_W-1:0] KN_UR = ACC_W'(-C_UR);
  localparam logic signed [ACC_W-1:0] KN_UG = ACC_W'(-C_UG);
  localparam logic signed [ACC_W-1:0] K_HF  = ACC_W'(C_HF);
  localparam logic signed [ACC_W-1:0] KN_VG = ACC_W'(-C_VG);
  localparam logic signed [ACC_W-1:0] KN_VB = ACC_W'(-C_VB);
  localparam logic signed [ACC_W-1:0] K_RV  = ACC_W'(C_RV);
  localparam logic signed [ACC_W-1:0] KN_GU = ACC_W'(-C_GU);
  localparam logic signed [ACC_W-1:0] KN_GV = ACC_W'(-C_GV);
  localparam logic signed [ACC_W-1:0] K_BU  = ACC_W'(C_BU);
  localparam logic signed [ACC_W-1:0] K_ONE = ACC_W'(C_ONE);
  localparam logic signed [ACC_W-1:0] K_ZERO = '0;

  logic                          v_r;
  ryuv_pix_t                     pix_r;
  logic [8:0][ACC_W-1:0]         term_r;
  logic [8:0][ACC_W-1:0]         term_nxt;
  logic signed [ACC_W-1:0]       ea, eb, ec, eu, ev;
  logic signed [BYTE_W:0]        u9, v9;
  logic signed [ACC_W-1:0]       kc [9];
  logic signed [ACC_W-1:0]       xo [9];
  logic signed [ACC_W-1:0]       prod;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_pix   = pix_r;
  assign dn_term  = term_r;

  // operand extension and chroma offset removal
  always_comb begin
    u9 = $signed({1'b0, up_pix.second}) - $signed((BYTE_W+1)'(CHROMA_OFS));
    v9 = $signed({1'b0, up_pix.third}) - $signed((BYTE_W+1)'(CHROMA_OFS));
    ea = $signed({{(ACC_W-BYTE_W){1'b0}}, up_pix.first});
    eb = $signed({{(ACC_W-BYTE_W){1'b0}}, up_pix.second});
    ec = $signed({{(ACC_W-BYTE_W){1'b0}}, up_pix.third});
    eu = $signed({{(ACC_W-BYTE_W-1){u9[BYTE_W]}}, u9});
    ev = $signed({{(ACC_W-BYTE_W-1){v9[BYTE_W]}}, v9});
  end

  // coefficient and operand select per mode, one multiplier per slot
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      kc[i] = K_ZERO;
      xo[i] = K_ZERO;
    end
    case (up_pix.mode)
      MODE_RGB2YUV: begin
        kc[0] = K_YR;  xo[0] = ea;
        kc[1] = K_YG;  xo[1] = eb;
        kc[2] = K_YB;  xo[2] = ec;
        kc[3] = KN_UR; xo[3] = ea;
        kc[4] = KN_UG; xo[4] = eb;
        kc[5] = K_HF;  xo[5] = ec;
        kc[6] = K_HF;  xo[6] = ea;
        kc[7] = KN_VG; xo[7] = eb;
        kc[8] = KN_VB; xo[8] = ec;
      end
      MODE_YUV2RGB: begin
        kc[0] = K_ONE; xo[0] = ea;
        kc[1] = K_RV;  xo[1] = ev;
        kc[3] = K_ONE; xo[3] = ea;
        kc[4] = KN_GU; xo[4] = eu;
        kc[5] = KN_GV; xo[5] = ev;
        kc[6] = K_ONE; xo[6] = ea;
        kc[7] = K_BU;  xo[7] = eu;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    prod = '0;
    for (int i = 0; i < 9; i++) begin
      prod        = kc[i] * xo[i];
      term_nxt[i] = prod;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r  <= up_pix;
      term_r <= term_nxt;
    end
  end

endmodule

// ----- design/ryuv_acc.sv -----
// sum stage: three terms plus rounding and chroma bias per channel
module ryuv_acc
  import ryuv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_W     = FRAC_BITS + 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  ryuv_pix_t                  up_pix,
  input  logic [8:0][ACC_W-1:0]      up_term,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output ryuv_pix_t                  dn_pix,
  output logic [2:0][ACC_W-1:0]      dn_sum
);

  localparam logic signed [ACC_W-1:0] K_HALF = ACC_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] K_OFS_HALF =
    ACC_W'((longint'(CHROMA_OFS) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1)));

  logic                      v_r;
  ryuv_pix_t                 pix_r;
  logic [2:0][ACC_W-1:0]     sum_r;
  logic [2:0][ACC_W-1:0]     sum_nxt;
  logic signed [ACC_W-1:0]   bias;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_pix   = pix_r;
  assign dn_sum   = sum_r;

  // chroma rows of the forward transform carry the 128 offset
  always_comb begin
    bias = K_HALF;
    for (int r = 0; r < 3; r++) begin
      bias = (up_pix.mode == MODE_RGB2YUV && r != 0) ? K_OFS_HALF : K_HALF;
      sum_nxt[r] = $signed(up_term[3*r]) + $signed(up_term[3*r+1])
                 + $signed(up_term[3*r+2]) + bias;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pix_r <= up_pix;
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- design/ryuv_clip.sv -----
// output stage: clamp, scale down, saturate, and mode select into the output register
module ryuv_clip
  import ryuv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_W     = FRAC_BITS + 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  ryuv_pix_t                  up_pix,
  input  logic [2:0][ACC_W-1:0]      up_sum,
  ryuv_out_if.source                 out_px
);

  logic                    v_r;
  logic [2:0][BYTE_W-1:0]  byte_r;
  logic [2:0][BYTE_W-1:0]  byte_nxt;
  logic [2:0][BYTE_W-1:0]  clip;
  logic [2:0][BYTE_W-1:0]  raw;

  assign up_ready     = !v_r || out_px.ready;
  assign out_px.valid = v_r;
  assign out_px.out_first  = byte_r[0];
  assign out_px.out_second = byte_r[1];
  assign out_px.out_third  = byte_r[2];

  assign raw[0] = up_pix.first;
  assign raw[1] = up_pix.second;
  assign raw[2] = up_pix.third;

  // negative to zero, drop fraction, saturate at full scale
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (up_sum[r][ACC_W-1]) begin
        clip[r] = '0;
      end else if (|up_sum[r][ACC_W-2:FRAC_BITS+BYTE_W]) begin
        clip[r] = BYTE_W'(BYTE_MAX);
      end else begin
        clip[r] = up_sum[r][FRAC_BITS+BYTE_W-1:FRAC_BITS];
      end
    end
  end

  // per-mode result select
  always_comb begin
    case (up_pix.mode)
      MODE_RGB2YUV, MODE_YUV2RGB: byte_nxt = clip;
      MODE_INVERT:                byte_nxt = ~raw;
      default:                    byte_nxt = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ----- design/rgb_yuv_pixel_converter_unit.sv -----
// BT.601 style RGB/YUV pixel converter: a four-register pipeline, one pixel per clock
// while out_px does not stall. The converter takes one pixel request per clock cycle while
// nothing stalls and returns one converted pixel per request, in order. Every request
// passes four registers (input capture, nine products, channel sums, output clamp); the
// sustained rate is one pixel per cycle when out_px does not stall, set by the pipeline
// having one multiplier per coefficient slot. Each stage frees itself when its successor
// takes its item, so a stall on out_px fills bubbles first and then holds in_px.ready low.
// cfg_wr is always ready and sets the mode: 0 RGB to YUV, 1 YUV to RGB, 2 invert each
// channel, 3 pass through; the mode travels with each pixel from the capture stage on.
module rgb_yuv_pixel_converter_unit
  import ryuv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ryuv_in_if.sink      in_px,
  ryuv_out_if.source   out_px,
  ryuv_cfg_if.sink     cfg_wr
);

  localparam int ACC_W = FRAC_BITS + 11;

  logic [MODE_W-1:0]       mode_r;
  logic                    s0_v_r;
  logic                    s0_ready;
  ryuv_pix_t               s0_pix_r;
  ryuv_pix_t               s0_pix_nxt;

  logic                    p_valid, p_ready;
  ryuv_pix_t               p_pix;
  logic [8:0][ACC_W-1:0]   p_term;

  logic                    a_valid, a_ready;
  ryuv_pix_t               a_pix;
  logic [2:0][ACC_W-1:0]   a_sum;

  // mode register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGB2YUV;
    end else if (cfg_wr.valid) begin
      mode_r <= cfg_wr.conversion_mode;
    end
  end

  // input capture stage
  assign in_px.ready = !s0_v_r || s0_ready;
  assign s0_pix_nxt  = '{mode: mode_r, first: in_px.in_first,
                         second: in_px.in_second, third: in_px.in_third};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_px.ready) begin
      s0_v_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_px.ready && in_px.valid) begin
      s0_pix_r <= s0_pix_nxt;
    end
  end

  ryuv_prod #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s0_v_r),
    .up_ready (s0_ready),
    .up_pix   (s0_pix_r),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_pix   (p_pix),
    .dn_term  (p_term)
  );

  ryuv_acc #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_pix   (p_pix),
    .up_term  (p_term),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_pix   (a_pix),
    .dn_sum   (a_sum)
  );

  ryuv_clip #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_pix   (a_pix),
    .up_sum   (a_sum),
    .out_px   (out_px)
  );

`ifndef SYNTH
  // a request is refused only while the capture stage holds an item
  a_refuse_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> s0_v_r)
    else $error("input refused with empty capture stage");

  // a stalled capture stage keeps its pixel and mode
  a_capture_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && !s0_ready |=> $stable(s0_pix_r))
    else $error("capture stage changed while stalled");

  // an open output never backs up to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.ready |-> in_px.ready)
    else $error("input stalled while output ready");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the rgb/yuv pixel converter: directed corners, random pixels, stalls
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ryuv_pkg::*;

  // fixed point coefficients, rounded to nearest at FRAC_BITS_DEF fraction bits
  localparam int     FRAC    = FRAC_BITS_DEF;
  localparam longint ONE_Q   = longint'(1) << FRAC;
  localparam longint HALF_Q  = longint'(1) << (FRAC - 1);
  localparam longint K_YR    = (299 * ONE_Q + 500) / 1000;
  localparam longint K_YG    = (587 * ONE_Q + 500) / 1000;
  localparam longint K_YB    = (114 * ONE_Q + 500) / 1000;
  localparam longint K_UR    = (169 * ONE_Q + 500) / 1000;
  localparam longint K_UG    = (331 * ONE_Q + 500) / 1000;
  localparam longint K_HALF  = (500 * ONE_Q + 500) / 1000;
  localparam longint K_VG    = (419 * ONE_Q + 500) / 1000;
  localparam longint K_VB    = (81 * ONE_Q + 500) / 1000;
  localparam longint K_RV    = (14075 * ONE_Q + 5000) / 10000;
  localparam longint K_GU    = (3455 * ONE_Q + 5000) / 10000;
  localparam longint K_GV    = (7169 * ONE_Q + 5000) / 10000;
  localparam longint K_BU    = (17790 * ONE_Q + 5000) / 10000;

  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 120;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  ryuv_in_if  in_px ();
  ryuv_out_if out_px ();
  ryuv_cfg_if cfg_wr ();

  rgb_yuv_pixel_converter_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px),
    .cfg_wr (cfg_wr)
  );

  // converted pixels still owed by the block, oldest first
  pixel_t            pending_pixels[$];
  logic [MODE_W-1:0] cur_mode;
  bit                modes_seen[4];
  int                pixels_sent;
  int                results_checked;
  int                errors;
  int                hold_cycles;
  bit                src_steady;
  bit                sink_steady;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round, clamp negatives, drop fraction bits, saturate at full scale
  function automatic logic [BYTE_W-1:0] saturate_byte(input longint acc);
    longint s;
    s = acc + HALF_Q;
    if (s < 0) s = 0;
    s = s >>> FRAC;
    return (s > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : s[BYTE_W-1:0];
  endfunction

  // expected converted pixel for one input pixel under a given mode
  function automatic pixel_t predict_pixel(input logic [MODE_W-1:0] mode,
                                           input logic [BYTE_W-1:0] f, s, t);
    longint a, b, c, ofs, u, v;
    pixel_t r;
    a   = longint'(f);
    b   = longint'(s);
    c   = longint'(t);
    ofs = CHROMA_OFS * ONE_Q;
    case (mode)
      MODE_RGB2YUV: begin
        r.first  = saturate_byte(K_YR * a + K_YG * b + K_YB * c);
        r.second = saturate_byte(-K_UR * a - K_UG * b + K_HALF * c + ofs);
        r.third  = saturate_byte(K_HALF * a - K_VG * b - K_VB * c + ofs);
      end
      MODE_YUV2RGB: begin
        u = b - CHROMA_OFS;
        v = c - CHROMA_OFS;
        r.first  = saturate_byte(a * ONE_Q + K_RV * v);
        r.second = saturate_byte(a * ONE_Q - K_GU * u - K_GV * v);
        r.third  = saturate_byte(a * ONE_Q + K_BU * u);
      end
      MODE_INVERT: begin
        r.first  = BYTE_MAX[BYTE_W-1:0] - f;
        r.second = BYTE_MAX[BYTE_W-1:0] - s;
        r.third  = BYTE_MAX[BYTE_W-1:0] - t;
      end
      default: begin
        r.first  = f;
        r.second = s;
        r.third  = t;
      end
    endcase
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want, got);
    if (got !== want)
      note_error($sformatf("%s mismatch: expected %0d got %0d", name, want, got));
  endtask

  // offer one pixel request and wait for it to be taken
  task automatic send_pixel(input logic [BYTE_W-1:0] f, s, t);
    int unsigned gap;
    gap = src_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid     <= 1'b1;
    in_px.in_first  <= f;
    in_px.in_second <= s;
    in_px.in_third  <= t;
    do @(posedge clk); while (!in_px.ready);
    pending_pixels.push_back(predict_pixel(cur_mode, f, s, t));
    pixels_sent++;
  endtask

  // mode change only once the pipeline has drained
  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr.valid           <= 1'b1;
    cfg_wr.conversion_mode <= m;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    cur_mode      = m;
    modes_seen[m] = 1'b1;
  endtask

  task automatic send_random(input int n);
    repeat (n)
      send_pixel(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)));
  endtask

  // register left at its reset value: rgb to yuv
  task automatic test_reset_mode();
    modes_seen[cur_mode] = 1'b1;
    send_random(8);
  endtask

  // black, white, pure primaries and mid gray in every mode
  task automatic test_corners();
    logic [BYTE_W-1:0] corner [6][3] = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
      '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd128, 8'd128, 8'd128}
    };
    logic [MODE_W-1:0] modes [4] = '{MODE_RGB2YUV, MODE_YUV2RGB, MODE_INVERT, MODE_PASS};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      foreach (corner[i]) send_pixel(corner[i][0], corner[i][1], corner[i][2]);
    end
  endtask

  task automatic test_random_mode(input logic [MODE_W-1:0] m, input int n);
    write_mode(m);
    send_random(n);
  endtask

  // receiver holds off while the sender keeps pushing, pipeline fills and stalls input
  task automatic test_backpressure();
    write_mode(MODE_RGB2YUV);
    src_steady  = 1'b1;
    hold_cycles = HOLD_CYCLES;
    send_random(40);
    src_steady  = 1'b0;
  endtask

  // back to back pixels with both sides always ready
  task automatic test_steady_stream();
    write_mode(MODE_YUV2RGB);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    send_random(80);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // receiver ready pattern, with an optional long hold requested by a test
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_px.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_px.ready <= 1'b0;
        hold_cycles--;
      end else if (sink_steady || stall_left == 0) begin
        out_px.ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 5) == 0) stall_left = idle_len();
      end else begin
        out_px.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // compare each converted pixel with the oldest prediction
  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_px.valid && out_px.ready) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("result %0d/%0d/%0d with no request pending",
                             out_px.out_first, out_px.out_second, out_px.out_third));
      end else begin
        want = pending_pixels.pop_front();
        results_checked++;
        check_field("out_first", want.first, out_px.out_first);
        check_field("out_second", want.second, out_px.out_second);
        check_field("out_third", want.third, out_px.out_third);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) ||
                 (cfg_wr.valid && cfg_wr.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("ERROR @%0t: no handshake for %0d cycles", $realtime, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    in_px.valid            <= 1'b0;
    in_px.in_first         <= '0;
    in_px.in_second        <= '0;
    in_px.in_third         <= '0;
    cfg_wr.valid           <= 1'b0;
    cfg_wr.conversion_mode <= MODE_RGB2YUV;
    cur_mode        = MODE_RGB2YUV;
    pixels_sent     = 0;
    results_checked = 0;
    errors          = 0;
    hold_cycles     = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_mode();
    test_corners();
    test_random_mode(MODE_PASS, 250);
    test_random_mode(MODE_YUV2RGB, 250);
    test_random_mode(MODE_RGB2YUV, 250);
    test_random_mode(MODE_INVERT, 250);
    test_backpressure();
    test_steady_stream();

    // drain and give stray results a chance to show
    in_px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_pixels.size()));

    $display("run: %0d pixels sent, %0d results checked, %0d errors", pixels_sent,
             results_checked, errors);
    $display("modes covered: rgb2yuv=%0d yuv2rgb=%0d invert=%0d pass=%0d, long output stall",
             modes_seen[0], modes_seen[1], modes_seen[2], modes_seen[3]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ryuv_pkg.sv
design/ryuv_in_if.sv
design/ryuv_out_if.sv
design/ryuv_cfg_if.sv
design/ryuv_prod.sv
design/ryuv_acc.sv
design/ryuv_clip.sv
design/rgb_yuv_pixel_converter_unit.sv
tb/tb_top.sv
